// File: sv/cp850_to_utf8_encoder_top_assert.svh
// Assertion macros for the CP850 to UTF-8 encoder.
`ifndef CP850_TO_UTF8_ENCODER_TOP_ASSERT_SVH
`define CP850_TO_UTF8_ENCODER_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define C2U8_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next clock cycle.
`define C2U8_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/c2u8_pkg.sv
// Shared types, constants and the code page ROM for the CP850 to UTF-8 encoder.
package c2u8_pkg;

  // Queue between the classify front end and the byte sender.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Encoding constants.
  localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;
  localparam logic [5:0]  CONT_MASK    = 6'h3F;

  // Sequence length codes.
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // One classified character: its UTF-8 bytes in send order and their count.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      len;
  } char_entry_t;

  // Head of the queue as seen by the sender.
  typedef struct packed {
    logic        valid;
    char_entry_t entry;
  } q_head_t;

  // Unicode code points of CP850 bytes 0x80 to 0xFF.
  localparam logic [15:0] HIGH_HALF_ROM [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
    16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
    16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
    16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
    16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
    16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
    16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
    16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

// File: sv/cp850_to_utf8_encoder_top.sv
// Top level of the CP850 to UTF-8 encoder.
//
// A code byte is taken at a clock edge with start high and busy low. Each
// character yields one to three UTF-8 bytes, one per cycle on utf8_byte with
// strobe high for that cycle; last_of_char marks the final byte. The receiver
// cannot hold bytes off, so they must be taken as they come. From an empty
// block, an accepted character passes the queue and the sender's cur register
// before its first byte is registered onto utf8_byte with strobe. The byte
// sender sets the pace: it sends a character's bytes back to back (one for
// ASCII, two or three for the upper half) and starts the next queued one
// without a gap. A zero byte is accepted and yields nothing. A two-entry queue
// sits between the classifier and the sender; busy is high while it is full.
module cp850_to_utf8_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] code_byte,
  output logic       busy,
  output logic       strobe,
  output logic [7:0] utf8_byte,
  output logic       last_of_char
);
  import c2u8_pkg::*;

  `include "cp850_to_utf8_encoder_top_assert.svh"

  logic        push;
  char_entry_t push_entry;
  q_head_t     head;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic        active;
  logic        idle_take;

  // Classify incoming beats.
  c2u8_front u_front (
    .start     (start),
    .code_byte (code_byte),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .entry     (push_entry)
  );

  // Buffer classified characters.
  c2u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Send bytes.
  c2u8_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .active       (active),
    .strobe       (strobe),
    .utf8_byte    (utf8_byte),
    .last_of_char (last_of_char)
  );

  // Nonzero beat taken while the whole block is idle.
  assign idle_take = start && !busy && (code_byte != 8'h00) && q_empty && !active;

  // A multi-byte sequence goes out without gaps.
  `C2U8_ASSERT_NEXT(a_seq_no_gap, strobe && !last_of_char, strobe, "gap inside UTF-8 sequence")

  // An idle block sends the first byte of a nonzero accept via queue and cur.
  `C2U8_ASSERT_NEXT(a_idle_latency, idle_take, ##2 strobe, "first byte late")

  // The sender only runs or pops with work available.
  `C2U8_ASSERT_ALWAYS(a_pop_has_data, !pop || !q_empty, "pop from empty queue")

endmodule

// File: sv/c2u8_front.sv
// Front end: accept a code byte, look up its code point and build its UTF-8 bytes.
module c2u8_front (
  input  logic                  start,
  input  logic [7:0]            code_byte,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  push,
  output c2u8_pkg::char_entry_t entry
);
  import c2u8_pkg::*;

  logic [15:0] cp;
  logic        accept;

  // Hold off new beats while the queue has no room.
  assign busy   = q_full;
  assign accept = start && !q_full;

  // Drop the string terminator: it yields no bytes.
  assign push = accept && (code_byte != 8'h00);

  // Look up the code point of the upper half.
  assign cp = HIGH_HALF_ROM[code_byte[6:0]];

  // Classify by sequence length and build the bytes.
  always_comb begin
    entry.bytes = '0;
    entry.len   = LEN_ONE;
    if (code_byte < ASCII_LIMIT) begin
      entry.bytes[0] = code_byte;
    end else if (cp < CP_ONE_LIMIT) begin
      entry.bytes[0] = cp[7:0];
    end else if (cp < CP_TWO_LIMIT) begin
      entry.len      = LEN_TWO;
      entry.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
      entry.bytes[1] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
    end else begin
      entry.len      = LEN_THREE;
      entry.bytes[0] = LEAD_THREE | {4'h0, cp[15:12]};
      entry.bytes[1] = CONT_MARK | {2'b00, cp[11:6] & CONT_MASK};
      entry.bytes[2] = CONT_MARK | {2'b00, cp[5:0] & CONT_MASK};
    end
  end

endmodule

// File: sv/c2u8_queue.sv
// Short queue of classified characters between the front end and the sender.
module c2u8_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  c2u8_pkg::char_entry_t push_entry,
  input  logic                  pop,
  output c2u8_pkg::q_head_t     head,
  output logic                  full,
  output logic                  empty
);
  import c2u8_pkg::*;

  char_entry_t          mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_pop;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign empty      = (count == '0);
  assign do_pop     = pop && !empty;
  assign head.valid = !empty;
  assign head.entry = mem[rd_ptr];

  // Write the pushed beat into its slot.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and track fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/c2u8_back.sv
// Back end: send the bytes of each queued character, one per cycle.
module c2u8_back (
  input  logic              clk,
  input  logic              rst,
  input  c2u8_pkg::q_head_t head,
  output logic              pop,
  output logic              active,
  output logic              strobe,
  output logic [7:0]        utf8_byte,
  output logic              last_of_char
);
  import c2u8_pkg::*;

  char_entry_t cur;
  logic [1:0]  idx;
  logic        at_last;
  logic [7:0]  cur_byte;

  // Pick the byte at the send index.
  always_comb begin
    case (idx)
      2'd0:    cur_byte = cur.bytes[0];
      2'd1:    cur_byte = cur.bytes[1];
      2'd2:    cur_byte = cur.bytes[2];
      default: cur_byte = cur.bytes[0];
    endcase
  end

  assign at_last = (idx == cur.len - 2'd1);
  assign pop     = head.valid && (!active || at_last);

  // Load the next character and drive the output bytes.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.entry;
    end
    if (active) begin
      utf8_byte    <= cur_byte;
      last_of_char <= at_last;
    end
  end

  // Step through the sequence and strobe each byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        if (at_last) begin
          active <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule

// File: test/cp850_to_utf8_encoder_top_test.sv
// Self-checking testbench for the CP850 to UTF-8 encoder top level.
`timescale 1ns / 100ps

module cp850_to_utf8_encoder_top_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int CHARS_PER_SET = 116;
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_CAP    = 10;

  // One UTF-8 output beat as the block should present it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  // Predicts the UTF-8 bytes of each taken code byte and checks the outputs.
  class utf8_scoreboard;
    utf8_beat_t  expected_beats[$];
    logic [15:0] cp_table[128];
    int          fail_count;
    int          chars_noted;
    int          terminators;
    int          bytes_checked;

    function new();
      cp_table = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
        16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
        16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
        16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
        16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
      };
      fail_count    = 0;
      chars_noted   = 0;
      terminators   = 0;
      bytes_checked = 0;
    endfunction

    function void push_beat(logic [7:0] data, logic last);
      utf8_beat_t beat;
      beat.data = data;
      beat.last = last;
      expected_beats = {expected_beats, beat};
    endfunction

    // Expand one taken code byte into its UTF-8 beats.
    function void note_char(logic [7:0] ch);
      logic [15:0] cp;
      chars_noted++;
      if (ch == 8'h00) begin
        // String terminator: nothing comes out
        terminators++;
        return;
      end
      if (ch < 8'h80) begin
        push_beat(ch, 1'b1);
        return;
      end
      cp = cp_table[ch[6:0]];
      if (cp < 16'h0080) begin
        push_beat(cp[7:0], 1'b1);
      end else if (cp < 16'h0800) begin
        push_beat({3'b110, cp[10:6]}, 1'b0);
        push_beat({2'b10, cp[5:0]}, 1'b1);
      end else begin
        push_beat({4'b1110, cp[15:12]}, 1'b0);
        push_beat({2'b10, cp[11:6]}, 1'b0);
        push_beat({2'b10, cp[5:0]}, 1'b1);
      end
    endfunction

    function void flag_failure(string what);
      fail_count++;
      if (fail_count <= REPORT_CAP) $display("ERROR: %s", what);
    endfunction

    // Compare one output beat with the oldest prediction.
    function void check_byte(logic [7:0] data, logic last);
      utf8_beat_t want;
      bytes_checked++;
      if (expected_beats.size() == 0) begin
        flag_failure($sformatf("unexpected beat data=%02h last=%0b", data, last));
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data)
        flag_failure($sformatf("beat %0d utf8_byte expected %02h actual %02h",
                               bytes_checked, want.data, data));
      if (last !== want.last)
        flag_failure($sformatf("beat %0d last_of_char expected %0b actual %0b",
                               bytes_checked, want.last, last));
    endfunction

    function int pending_count();
      return expected_beats.size();
    endfunction

    // Anything still queued at the end never came out.
    function void close_out();
      if (expected_beats.size() != 0)
        flag_failure($sformatf("%0d predicted beats never arrived", expected_beats.size()));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] code_byte = 8'h00;
  logic       busy;
  logic       strobe;
  logic [7:0] utf8_byte;
  logic       last_of_char;

  utf8_scoreboard sb = new();
  int taken_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;

  cp850_to_utf8_encoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .code_byte    (code_byte),
    .busy         (busy),
    .strobe       (strobe),
    .utf8_byte    (utf8_byte),
    .last_of_char (last_of_char)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes at the rising edge; bound the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (start && !busy) begin
        sb.note_char(code_byte);
        taken_count++;
      end
      if (strobe) sb.check_byte(utf8_byte, last_of_char);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("cp850_to_utf8_encoder_top verification failed");
      $finish;
    end
  end

  // Drive one code byte beat; called at a falling edge, returns at one.
  // start stays high on return so back-to-back beats need no low pulse.
  task automatic send_char(input logic [7:0] ch);
    int goal;
    while ($urandom_range(99) < sender_idle_pct) begin
      start     <= 1'b0;
      code_byte <= 8'($urandom);
      @(negedge clk);
    end
    start     <= 1'b1;
    code_byte <= ch;
    goal = taken_count + 1;
    do @(negedge clk); while (taken_count != goal);
  endtask

  // Mostly high-half characters, a fair share of ASCII, an occasional terminator.
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 8'h00;
    if (roll < 40) return 8'($urandom_range(127, 1));
    return 8'($urandom_range(255, 128));
  endfunction

  // Send one set of random characters; terminators do not count toward it.
  task automatic send_random_set(input int idle_pct);
    int sent;
    logic [7:0] ch;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < CHARS_PER_SET) begin
      ch = pick_char();
      send_char(ch);
      if (ch != 8'h00) sent++;
    end
  endtask

  logic [7:0] directed_chars[] = '{
    8'h41, 8'h00, 8'h01, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'h9F,
    8'hB0, 8'hB1, 8'hB2, 8'hDB, 8'hD5, 8'hDF, 8'hF2, 8'hFE,
    8'h20, 8'h00, 8'h00, 8'hAA, 8'hC5, 8'h55, 8'hE1
  };

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: range ends, every sequence length, terminators, full queue
    sender_idle_pct = 0;
    foreach (directed_chars[i]) send_char(directed_chars[i]);

    send_random_set(27);
    send_random_set(80);
    send_random_set(0);

    start <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.close_out();

    $display("Fed %0d code bytes (%0d terminators) with varied sender gaps,",
             sb.chars_noted, sb.terminators);
    $display("checked %0d UTF-8 output bytes, %0d failures", sb.bytes_checked,
             sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("cp850_to_utf8_encoder_top verification clean");
    end else begin
      $display("cp850_to_utf8_encoder_top verification failed");
    end
    $finish;
  end

endmodule

// File: cp850_to_utf8_encoder_top.f
+incdir+sv
sv/c2u8_pkg.sv
sv/c2u8_front.sv
sv/c2u8_queue.sv
sv/c2u8_back.sv
sv/cp850_to_utf8_encoder_top.sv
test/cp850_to_utf8_encoder_top_test.sv
